[rtl/core/tws_pkg.sv]
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants of the two-wire sensor bus master.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int unsigned NUM_CHANNELS = 2;
  localparam int unsigned CH_W         = 2;   // line level vectors, one bit per channel

  // group indices that mark the steps of each sequence
  localparam logic [4:0] RESET_LOOP_END = 5'd18;
  localparam logic [4:0] START_LAST     = 5'd6;
  localparam logic [4:0] BYTE_LAST_CLK  = 5'd16;
  localparam logic [4:0] ACK_CLK_HIGH   = 5'd17;
  localparam logic [4:0] ACK_CLK_LOW    = 5'd18;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_RESET = 3'd1,
    CMD_START = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // classified request as held in the queue
  typedef struct packed {
    cmd_e       cmd;
    logic       sel;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       line_a;
    logic       line_b;
  } item_t;

  typedef struct packed {
    logic       nack_error;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       data_b;
    logic       clock_b;
    logic       data_a;
    logic       clock_a;
  } result_t;

endpackage

[rtl/core/tws_front.sv]
// ----------------------------------------------------------------------------
// tws_front
// Accepts requests, decodes the action and queues them for the sequencer.
// ----------------------------------------------------------------------------
module tws_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    action_i,
  input  logic          sel_i,
  input  logic [7:0]    tx_byte_i,
  input  logic          ack_level_i,
  input  logic          line_a_i,
  input  logic          line_b_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output tws_pkg::item_t q_item_o
);
  import tws_pkg::*;

  localparam int unsigned Depth = 2;

  item_t       entry_q [Depth];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  item_t       item;
  logic        push;
  logic        chan_ok;

  assign chan_ok = ({1'b0, sel_i} < 2'(NUM_CHANNELS));

  always_comb begin
    item           = '0;
    item.sel       = sel_i;
    item.tx_byte   = tx_byte_i;
    item.ack_level = ack_level_i;
    item.line_a    = line_a_i;
    item.line_b    = line_b_i;
    unique case (action_i)
      3'd1:    item.cmd = chan_ok ? CMD_RESET : CMD_IDLE;
      3'd2:    item.cmd = chan_ok ? CMD_START : CMD_IDLE;
      3'd3:    item.cmd = chan_ok ? CMD_WRITE : CMD_IDLE;
      3'd4:    item.cmd = chan_ok ? CMD_READ  : CMD_IDLE;
      default: item.cmd = CMD_IDLE;
    endcase
  end

  assign in_ready_o = (count_q != 2'(Depth));
  assign push       = in_valid_i & in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(Depth)) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> count_q != 2'd0) else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q)) else $error("queue pointers out of step");
`endif

endmodule

[rtl/core/tws_back.sv]
// ----------------------------------------------------------------------------
// tws_back
// Pin sequencer: runs one tick per queued request and registers the result.
// ----------------------------------------------------------------------------
module tws_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  tws_pkg::item_t q_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tws_pkg::result_t out_res_o
);
  import tws_pkg::*;

  logic [7:0]      half_q;
  cmd_e            cmd_q, cmd_d, cmd_eff;
  logic [4:0]      phase_q, phase_d, phase_eff, sg;
  logic [7:0]      wait_q, wait_d, hp;
  logic            chan_q, chan_d, chan_eff;
  logic [7:0]      sw_q, sw_d, sw_eff, sw_next;
  logic            ackh_q, ackh_d, ackh_eff;
  logic [CH_W-1:0] clk_q, clk_d, dat_q, dat_d;
  logic            nack_q, nack_d;
  logic [7:0]      rx_q, rx_d;
  logic            out_valid_q;
  result_t         out_q, res;

  logic       run, last, line;
  logic       clk_en, clk_val, dat_en, dat_val, nack_en, rx_en, in_start;
  logic [3:0] k, kr;

  assign q_pop_o = q_valid_i & (~out_valid_q | out_ready_i);
  assign hp      = (half_q == 8'd0) ? 8'd1 : half_q;

  always_comb begin
    run       = 1'b0;
    cmd_eff   = cmd_q;
    chan_eff  = chan_q;
    sw_eff    = sw_q;
    phase_eff = phase_q;
    ackh_eff  = ackh_q;
    wait_d    = wait_q;
    if (q_pop_o) begin
      if (cmd_q == CMD_IDLE) begin
        if (q_item_i.cmd != CMD_IDLE) begin
          cmd_eff   = q_item_i.cmd;
          chan_eff  = q_item_i.sel;
          phase_eff = 5'd0;
          ackh_eff  = q_item_i.ack_level;
          sw_eff    = (q_item_i.cmd == CMD_WRITE) ? q_item_i.tx_byte : 8'd0;
          run       = 1'b1;
        end
      end else if (wait_q > 8'd1) begin
        wait_d = wait_q - 8'd1;
      end else begin
        run = 1'b1;
      end
    end
  end

  assign line = chan_eff ? q_item_i.line_b : q_item_i.line_a;
  assign k    = phase_eff[4:1];
  assign kr   = k - 4'd1;

  // group decode
  always_comb begin
    clk_en   = 1'b0;
    clk_val  = 1'b0;
    dat_en   = 1'b0;
    dat_val  = 1'b1;
    nack_en  = 1'b0;
    rx_en    = 1'b0;
    last     = 1'b0;
    sw_next  = sw_eff;
    in_start = 1'b0;
    sg       = phase_eff;
    unique case (cmd_eff)
      CMD_RESET: begin
        if (phase_eff > RESET_LOOP_END) begin
          in_start = 1'b1;
          sg       = phase_eff - RESET_LOOP_END;
        end else begin
          dat_en  = (phase_eff == 5'd0) || (phase_eff == RESET_LOOP_END);
          dat_val = 1'b1;
          clk_en  = 1'b1;
          clk_val = phase_eff[0];
        end
      end
      CMD_START: in_start = 1'b1;
      CMD_WRITE: begin
        if (phase_eff == 5'd0) begin
          dat_en  = 1'b1;
          dat_val = sw_eff[7];
        end else if (phase_eff <= BYTE_LAST_CLK) begin
          clk_en = 1'b1;
          if (phase_eff[0]) begin
            clk_val = 1'b1;
          end else begin
            clk_val = 1'b0;
            dat_en  = 1'b1;
            dat_val = (k <= 4'd7) ? sw_eff[3'(4'd7 - k)] : 1'b1;
          end
        end else if (phase_eff == ACK_CLK_HIGH) begin
          clk_en  = 1'b1;
          clk_val = 1'b1;
        end else if (phase_eff == ACK_CLK_LOW) begin
          nack_en = 1'b1;
          clk_en  = 1'b1;
          clk_val = 1'b0;
        end else begin
          last = 1'b1;
        end
      end
      CMD_READ: begin
        if (phase_eff == 5'd0) begin
          dat_en  = 1'b1;
          dat_val = 1'b1;
        end else if (phase_eff <= BYTE_LAST_CLK) begin
          clk_en = 1'b1;
          if (phase_eff[0]) begin
            clk_val = 1'b0;
          end else begin
            clk_val = 1'b1;
            sw_next = sw_eff | (8'(line) << 3'(4'd7 - kr));
            if (phase_eff == BYTE_LAST_CLK) begin
              dat_en  = 1'b1;
              dat_val = ackh_eff;
            end
          end
        end else if (phase_eff == ACK_CLK_HIGH) begin
          clk_en  = 1'b1;
          clk_val = 1'b1;
        end else begin
          clk_en  = 1'b1;
          clk_val = 1'b0;
          dat_en  = 1'b1;
          dat_val = 1'b1;
          rx_en   = 1'b1;
          last    = 1'b1;
        end
      end
      default: last = 1'b1;
    endcase
    if (in_start) begin
      unique case (sg)
        5'd0: begin dat_en = 1'b1; dat_val = 1'b1; end
        5'd1: begin clk_en = 1'b1; clk_val = 1'b1; end
        5'd2: begin dat_en = 1'b1; dat_val = 1'b0; end
        5'd3: begin clk_en = 1'b1; clk_val = 1'b0; end
        5'd4: begin clk_en = 1'b1; clk_val = 1'b1; end
        5'd5: begin dat_en = 1'b1; dat_val = 1'b1; end
        default: begin clk_en = 1'b1; clk_val = 1'b0; last = 1'b1; end
      endcase
    end
  end

  always_comb begin
    cmd_d   = cmd_q;
    phase_d = phase_q;
    chan_d  = chan_q;
    sw_d    = sw_q;
    ackh_d  = ackh_q;
    clk_d   = clk_q;
    dat_d   = dat_q;
    nack_d  = nack_q;
    rx_d    = rx_q;
    if (run) begin
      chan_d = chan_eff;
      sw_d   = sw_next;
      ackh_d = ackh_eff;
      if (clk_en) clk_d[chan_eff] = clk_val;
      if (dat_en) dat_d[chan_eff] = dat_val;
      if (nack_en) nack_d = line;
      if (rx_en) rx_d = sw_eff;
      if (last) begin
        cmd_d   = CMD_IDLE;
        phase_d = 5'd0;
      end else begin
        cmd_d   = cmd_eff;
        phase_d = phase_eff + 5'd1;
      end
    end
  end

  always_comb begin
    res            = '0;
    res.clock_a    = clk_d[0];
    res.data_a     = dat_d[0];
    res.clock_b    = clk_d[1];
    res.data_b     = dat_d[1];
    res.busy_res   = (cmd_d != CMD_IDLE);
    res.done_res   = run & last;
    res.rx_byte    = rx_d;
    res.nack_error = nack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= 8'd1;
      cmd_q       <= CMD_IDLE;
      phase_q     <= 5'd0;
      wait_q      <= 8'd0;
      chan_q      <= 1'b0;
      sw_q        <= 8'd0;
      ackh_q      <= 1'b0;
      clk_q       <= '0;
      dat_q       <= '1;
      nack_q      <= 1'b0;
      rx_q        <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) half_q <= cfg_wdata_i;
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      chan_q  <= chan_d;
      sw_q    <= sw_d;
      ackh_q  <= ackh_d;
      clk_q   <= clk_d;
      dat_q   <= dat_d;
      nack_q  <= nack_d;
      rx_q    <= rx_d;
      if (run) begin
        wait_q <= last ? 8'd0 : hp;
      end else begin
        wait_q <= wait_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.done_res && out_q.busy_res)) else $error("done while busy");
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q == CMD_IDLE) |-> (phase_q == 5'd0 && wait_q == 8'd0)) else $error("idle not clean");
  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= RESET_LOOP_END + START_LAST) else $error("phase out of range");
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_pop_o |=> $stable(phase_q)) else $error("sequencer moved without a request");
`endif

endmodule

[rtl/core/two_wire_sensor_bus_master.sv]
// ----------------------------------------------------------------------------
// two_wire_sensor_bus_master
// Bit-level master for a two-channel two-wire humidity-sensor bus.
//
//   channel   dir  tdata (low bit up)                                 tuser
//   s_axis    in   action[2:0] tx_byte[7:0] ack_level line_in_a       sensor_select
//                  line_in_b, zero pad to 16
//   m_axis    out  clock_a data_a clock_b data_b busy_res done_res    -
//                  rx_byte[7:0] nack_error, zero pad to 16
//   cfg       in   half_period_ticks[7:0]                             -
//
// one request is one tick and gives one result; one request per cycle while the output is not stalled
// a request reaches its result through the queue and then the output register
// a stalled output fills the two-entry queue, then s_axis_tready drops
// reset returns to idle, delay register to one, lines low clock / high data
// ----------------------------------------------------------------------------
module two_wire_sensor_bus_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,      // half_period_ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,     // action, tx_byte, ack_level, line_in_a, line_in_b
  input  logic        s_axis_tuser,     // sensor_select
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata      // clock_a, data_a, clock_b, data_b, busy_res,
                                        // done_res, rx_byte, nack_error
);
  import tws_pkg::*;

  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  tws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tdata[2:0]),
    .sel_i       (s_axis_tuser),
    .tx_byte_i   (s_axis_tdata[10:3]),
    .ack_level_i (s_axis_tdata[11]),
    .line_a_i    (s_axis_tdata[12]),
    .line_b_i    (s_axis_tdata[13]),
    .q_valid_o   (q_valid),
    .q_pop_i     (q_pop),
    .q_item_o    (q_item)
  );

  tws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {1'b0, res};

endmodule

[tb/sensor_bus_line_checker.sv]
// ----------------------------------------------------------------------------
// sensor_bus_line_checker
// Watches the request, result and register ports of the two-wire sensor bus
// master, keeps its own cycle model of the line sequencer and compares each
// result word field by field with the oldest predicted line state.
// ----------------------------------------------------------------------------
module sensor_bus_line_checker
  import tws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int          fail_count,
  output int          pending_count,
  output logic        line_busy
);

  localparam int REPORT_MAX = 10;

  logic [7:0] half_ticks;
  cmd_e       run_cmd;
  logic [4:0] grp;
  logic [7:0] wait_cnt;
  logic       chan;
  logic [1:0] clk_lv;
  logic [1:0] dat_lv;
  logic [7:0] shift_q;
  logic [7:0] rx_q;
  logic       nack_q;
  logic       ack_hold;
  int         fails;

  result_t    line_states_q[$];

  function automatic void drive_clk(input logic v);
    clk_lv[chan] = v;
  endfunction

  function automatic void drive_dat(input logic v);
    dat_lv[chan] = v;
  endfunction

  // transmission start pattern, returns 1 on its final group
  function automatic logic start_step(input logic [4:0] g);
    case (g)
      5'd0: drive_dat(1'b1);
      5'd1: drive_clk(1'b1);
      5'd2: drive_dat(1'b0);
      5'd3: drive_clk(1'b0);
      5'd4: drive_clk(1'b1);
      5'd5: drive_dat(1'b1);
      default: begin
        drive_clk(1'b0);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic bus_group(input logic [4:0] g, input logic line);
    logic [3:0] k;
    case (run_cmd)
      CMD_RESET: begin
        if (g > RESET_LOOP_END) return start_step(g - RESET_LOOP_END);
        if (g == 5'd0 || g == RESET_LOOP_END) drive_dat(1'b1);
        drive_clk(g[0]);
        return 1'b0;
      end
      CMD_START: return start_step(g);
      CMD_WRITE: begin
        if (g == 5'd0) begin
          drive_dat(shift_q[7]);
        end else if (g <= BYTE_LAST_CLK) begin
          if (g[0]) begin
            drive_clk(1'b1);
          end else begin
            k = g[4:1];
            drive_clk(1'b0);
            // after the last data bit the line is released for the ack
            drive_dat((k <= 4'd7) ? shift_q[3'(4'd7 - k)] : 1'b1);
          end
        end else if (g == ACK_CLK_HIGH) begin
          drive_clk(1'b1);
        end else if (g == ACK_CLK_LOW) begin
          nack_q = line;
          drive_clk(1'b0);
        end else begin
          return 1'b1;
        end
        return 1'b0;
      end
      CMD_READ: begin
        if (g == 5'd0) begin
          drive_dat(1'b1);
        end else if (g <= BYTE_LAST_CLK) begin
          if (g[0]) begin
            drive_clk(1'b0);
          end else begin
            k = 4'((g - 5'd2) >> 1);
            drive_clk(1'b1);
            shift_q[3'(4'd7 - k)] = shift_q[3'(4'd7 - k)] | line;
            if (g == BYTE_LAST_CLK) drive_dat(ack_hold);
          end
        end else if (g == ACK_CLK_HIGH) begin
          drive_clk(1'b1);
        end else begin
          drive_clk(1'b0);
          drive_dat(1'b1);
          rx_q = shift_q;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b1;
    endcase
  endfunction

  // one tick of the sequencer, returns the line state it leaves behind
  function automatic result_t step_bus(input logic [15:0] req, input logic sel);
    logic [2:0] act;
    logic       line;
    logic       run;
    logic       last;
    result_t    r;
    act  = req[2:0];
    run  = 1'b0;
    last = 1'b0;
    if (run_cmd == CMD_IDLE) begin
      if (act >= CMD_RESET && act <= CMD_READ) begin
        run_cmd  = cmd_e'(act);
        chan     = sel;
        grp      = '0;
        ack_hold = req[11];
        shift_q  = (act == CMD_WRITE) ? req[10:3] : 8'h00;
        run      = 1'b1;
      end
    end else if (wait_cnt > 8'd1) begin
      wait_cnt = wait_cnt - 8'd1;
    end else begin
      run = 1'b1;
    end
    if (run) begin
      line = chan ? req[13] : req[12];
      last = bus_group(grp, line);
      if (last) begin
        run_cmd  = CMD_IDLE;
        grp      = '0;
        wait_cnt = '0;
      end else begin
        grp      = grp + 5'd1;
        wait_cnt = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
      end
    end
    r.clock_a    = clk_lv[0];
    r.data_a     = dat_lv[0];
    r.clock_b    = clk_lv[1];
    r.data_b     = dat_lv[1];
    r.busy_res   = (run_cmd != CMD_IDLE);
    r.done_res   = last;
    r.rx_byte    = rx_q;
    r.nack_error = nack_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t got;
    result_t want;
    string   bad;
    if (!rst_ni) begin
      half_ticks = 8'd1;
      run_cmd    = CMD_IDLE;
      grp        = '0;
      wait_cnt   = '0;
      chan       = 1'b0;
      clk_lv     = 2'b00;
      dat_lv     = 2'b11;
      shift_q    = '0;
      rx_q       = '0;
      nack_q     = 1'b0;
      ack_hold   = 1'b0;
      fails      = 0;
      line_states_q.delete();
      fail_count    <= 0;
      pending_count <= 0;
      line_busy     <= 1'b0;
    end else begin
      if (cfg_we_i) half_ticks = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        line_states_q.push_back(step_bus(s_axis_tdata, s_axis_tuser));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[14:0]);
        if (line_states_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX) begin
            $display("unexpected bus result %h at %0t", m_axis_tdata, $realtime);
          end
        end else begin
          want = line_states_q.pop_front();
          bad  = "";
          if (got.clock_a    !== want.clock_a)    bad = {bad, " clock_a"};
          if (got.data_a     !== want.data_a)     bad = {bad, " data_a"};
          if (got.clock_b    !== want.clock_b)    bad = {bad, " clock_b"};
          if (got.data_b     !== want.data_b)     bad = {bad, " data_b"};
          if (got.busy_res   !== want.busy_res)   bad = {bad, " busy_res"};
          if (got.done_res   !== want.done_res)   bad = {bad, " done_res"};
          if (got.rx_byte    !== want.rx_byte)    bad = {bad, " rx_byte"};
          if (got.nack_error !== want.nack_error) bad = {bad, " nack_error"};
          if (m_axis_tdata[15] !== 1'b0)          bad = {bad, " pad"};
          if (bad != "") begin
            fails++;
            if (fails <= REPORT_MAX) begin
              $display("bus result mismatch in%s: expected %h, got %h at %0t",
                       bad, want, m_axis_tdata, $realtime);
            end
          end
        end
      end
      fail_count    <= fails;
      pending_count <= line_states_q.size();
      line_busy     <= (run_cmd != CMD_IDLE);
    end
  end

endmodule

[tb/two_wire_sensor_bus_master_tb.sv]
// ----------------------------------------------------------------------------
// two_wire_sensor_bus_master_tb
// Drives timing ticks and bus commands into the two-wire sensor bus master:
// a directed pass over every command, the byte extremes, spare action codes
// and commands sent while busy, then random command streams under several
// delay settings and idle/stall patterns, including a long output hold-off.
// ----------------------------------------------------------------------------
module two_wire_sensor_bus_master_tb;
  import tws_pkg::*;

  localparam int         LIMIT        = 1_000_000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         SETTLE       = 8;
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int         LN_LOW       = 0;
  localparam int         LN_HIGH      = 1;
  localparam int         LN_RAND      = 2;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic [15:0] s_axis_tdata  = 16'h0000;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;

  int          fails;
  int          pending;
  logic        line_busy;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          recv_hold      = 1'b0;

  always #5 clk_i = ~clk_i;

  two_wire_sensor_bus_master u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sensor_bus_line_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fails),
    .pending_count (pending),
    .line_busy     (line_busy)
  );

  // result side: random stalls, plus one long hold-off on demand
  initial begin
    forever begin
      @(posedge clk_i);
      if (recv_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int cyc;
    for (cyc = 0; cyc < LIMIT; cyc++) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // tdata: action, tx_byte, ack_level, line_in_a, line_in_b; tuser: sensor_select
  task automatic send_req(input logic [2:0] act, input logic sel, input logic [7:0] byt,
                          input logic ack, input logic la, input logic lb);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tdata  <= {2'b00, lb, la, ack, byt, act};
    s_axis_tuser  <= sel;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic line_level(input int lmode);
    return (lmode == LN_RAND) ? 1'($urandom_range(1)) : (lmode == LN_HIGH);
  endfunction

  // plain ticks until the sequence is over; the first one may carry a command
  task automatic tick_until_idle(input int lmode, input logic [2:0] first_act);
    logic [2:0] act;
    act = first_act;
    do begin
      send_req(act, 1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)),
               line_level(lmode), line_level(lmode));
      act = CMD_IDLE;
    end while (line_busy);
  endtask

  task automatic run_cmd(input logic [2:0] act, input logic sel, input logic [7:0] byt,
                         input logic ack, input int lmode, input logic [2:0] intrude);
    send_req(act, sel, byt, ack, line_level(lmode), line_level(lmode));
    tick_until_idle(lmode, intrude);
  endtask

  task automatic drain_bus;
    tick_until_idle(LN_RAND, CMD_IDLE);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic random_traffic(input int n_cmds);
    int         started;
    int         r;
    logic [2:0] act;
    logic [7:0] byt;
    started = 0;
    while (started < n_cmds) begin
      r = $urandom_range(99);
      if (!line_busy) begin
        if (r < 70) begin
          act = 3'($urandom_range(CMD_RESET, CMD_READ));
          started++;
        end else if (r < 80) begin
          act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end else begin
          act = CMD_IDLE;
        end
      end else begin
        if (r < 8) act = 3'($urandom_range(CMD_RESET, CMD_READ));
        else if (r < 12) act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        else act = CMD_IDLE;
      end
      case ($urandom_range(9))
        0: byt = 8'h00;
        1: byt = 8'hFF;
        default: byt = 8'($urandom);
      endcase
      send_req(act, 1'($urandom_range(1)), byt, 1'($urandom_range(1)),
               1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic run_phase(input logic [7:0] half, input int idle_pct, input int stall_pct,
                           input int n_cmds, input bit long_hold);
    drain_bus();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= half;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (long_hold) recv_hold = 1'b1;
    random_traffic(n_cmds);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, delay register at its reset value
    send_req(CMD_IDLE, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) begin
      send_req(3'(a), 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1);
    end
    run_cmd(CMD_RESET, 1'b0, 8'h00, 1'b0, LN_RAND, CMD_IDLE);
    run_cmd(CMD_START, 1'b1, 8'h00, 1'b0, LN_RAND, CMD_IDLE);
    run_cmd(CMD_WRITE, 1'b0, 8'hFF, 1'b0, LN_LOW, CMD_IDLE);
    run_cmd(CMD_WRITE, 1'b1, 8'h00, 1'b1, LN_HIGH, CMD_READ);
    run_cmd(CMD_READ, 1'b0, 8'h00, 1'b0, LN_HIGH, CMD_IDLE);
    run_cmd(CMD_READ, 1'b1, 8'hFF, 1'b1, LN_LOW, CMD_WRITE);
    run_cmd(CMD_READ, 1'b1, 8'hA5, 1'b1, LN_RAND, CMD_IDLE);
    run_cmd(CMD_RESET, 1'b1, 8'h3C, 1'b0, LN_RAND, CMD_START);
    run_cmd(CMD_WRITE, 1'b0, 8'h5A, 1'b0, LN_RAND, CMD_RESET);

    run_phase(8'd1, 0, 0, 3, 1'b1);
    run_phase(8'd2, 80, 0, 2, 1'b0);
    run_phase(8'd0, 0, 80, 4, 1'b0);
    run_phase(8'd3, 6, 6, 1, 1'b0);
    drain_bus();

    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
